// File: src/gspm_pkg.sv
`timescale 1ns / 1ps

package gspm_pkg;

    localparam int unsigned PATTERN_MAX_DEF = 63;

    localparam logic [7:0] STAR_BYTE  = 8'h2A;
    localparam logic [7:0] QMARK_BYTE = 8'h3F;

    typedef enum logic [1:0] {
        OP_PATTERN = 2'd0,
        OP_TEXT    = 2'd1,
        OP_END     = 2'd2
    } op_t;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic       restart;
        logic       advance;
        logic [7:0] sym;
    } cell_ctl_t;

    function automatic logic is_wildcard(input logic [7:0] b);
        return (b == STAR_BYTE) || (b == QMARK_BYTE);
    endfunction

endpackage

// File: src/gspm_cell.sv
`timescale 1ns / 1ps

module gspm_cell #(
    parameter bit HOME = 1'b0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gspm_pkg::cell_ctl_t ctl,
    input  logic                wr,
    input  logic                used,
    input  logic                seed,
    input  logic                carry_in,
    input  logic                step_in,
    output logic                closed,
    output logic                carry_out,
    output logic                step_out,
    output logic                raw
);
    import gspm_pkg::*;

    logic [7:0] byte_reg;
    logic       raw_reg;
    logic       raw_next;
    logic       is_star;
    logic       hit;

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            byte_reg <= ctl.sym;
        end
    end

    assign is_star = (byte_reg == STAR_BYTE);
    assign hit     = (byte_reg == QMARK_BYTE) || (byte_reg == ctl.sym);

    // raw set is kept before star closure; closure ripples in from the left
    assign closed    = raw_reg | carry_in;
    assign carry_out = closed & used & is_star;
    assign step_out  = closed & used & ~is_star & hit;
    assign raw       = raw_reg;

    always_comb
    begin
        priority if (ctl.restart)
        begin
            raw_next = seed;
        end
        else if (ctl.advance)
        begin
            raw_next = carry_out | step_in | seed;
        end
        else
        begin
            raw_next = raw_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg <= HOME;
        end
        else
        begin
            raw_reg <= raw_next;
        end
    end

endmodule

// File: src/glob_or_substring_path_match.sv
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// cmd       into       cmd_valid / cmd_ready     op, symbol, first
// rsp       out of     rsp_valid / rsp_ready     matched, pattern_overflow
//
// one request per cycle of any op while cmd_ready is high
// the end op answers in the next cycle from the result register
// the star closure ripples combinationally through the row of cells
// reset leaves an empty pattern, which matches any text
// only an end request waits when the result register is full and stalled

module glob_or_substring_path_match #(
    parameter int unsigned PATTERN_MAX = gspm_pkg::PATTERN_MAX_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  logic [1:0] op,
    input  logic [7:0] symbol,
    input  logic       first,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output logic       matched,
    output logic       pattern_overflow
);
    import gspm_pkg::*;

    localparam int unsigned NPOS  = PATTERN_MAX + 1;
    localparam int unsigned LEN_W = $clog2(NPOS);

    logic             cmd_fire;
    logic             is_pat;
    logic             is_text;
    logic             is_end;
    logic             room;
    logic [LEN_W-1:0] widx;
    cell_ctl_t        ctl;

    logic [LEN_W-1:0] length_reg;
    logic [LEN_W-1:0] length_next;
    logic             wild_reg;
    logic             wild_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             found_reg;
    logic             found_next;
    logic             pend_reg;
    logic             pend_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    logic             matched_reg;
    logic             rsp_ovf_reg;

    logic [NPOS-1:0]  closed;
    logic [NPOS-1:0]  carry;
    logic [NPOS-1:0]  step;
    logic [NPOS-1:0]  raw;
    logic             at_end;
    logic             found_eff;
    logic             answer;

    assign cmd_ready = (op != OP_END) || !rsp_valid_reg || rsp_ready;
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign is_pat    = cmd_fire && (op == OP_PATTERN);
    assign is_text   = cmd_fire && (op == OP_TEXT);
    assign is_end    = cmd_fire && (op == OP_END);

    assign room = first || (length_reg < LEN_W'(PATTERN_MAX));
    assign widx = first ? '0 : length_reg;

    assign ctl.restart = is_pat || is_end;
    assign ctl.advance = is_text;
    assign ctl.sym     = symbol;

    for (genvar i = 0; i < NPOS; i++)
    begin : g_cell
        logic seed_i;
        logic carry_i;
        logic step_i;

        if (i == 0)
        begin : g_head
            // position zero is re-seeded on every byte in substring mode
            assign seed_i  = ctl.restart ? 1'b1 : !wild_reg;
            assign carry_i = 1'b0;
            assign step_i  = 1'b0;
        end
        else
        begin : g_body
            assign seed_i  = 1'b0;
            assign carry_i = carry[i-1];
            assign step_i  = step[i-1];
        end

        gspm_cell #(
            .HOME (i == 0)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .wr        (is_pat && room && (widx == LEN_W'(i))),
            .used      (LEN_W'(i) < length_reg),
            .seed      (seed_i),
            .carry_in  (carry_i),
            .step_in   (step_i),
            .closed    (closed[i]),
            .carry_out (carry[i]),
            .step_out  (step[i]),
            .raw       (raw[i])
        );
    end

    assign at_end = closed[length_reg];
    // the substring check of the last text byte lands in the following cycle via pend_reg
    assign found_eff = found_reg || (pend_reg && !wild_reg && at_end);

    always_comb
    begin
        priority if (ovf_reg)
        begin
            answer = 1'b0;
        end
        else if (wild_reg)
        begin
            answer = at_end;
        end
        else
        begin
            answer = found_eff || at_end;
        end
    end

    always_comb
    begin
        length_next    = length_reg;
        wild_next      = wild_reg;
        ovf_next       = ovf_reg;
        found_next     = found_eff;
        pend_next      = is_text;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        if (is_pat)
        begin
            if (room)
            begin
                length_next = widx + LEN_W'(1);
                wild_next   = (!first && wild_reg) || is_wildcard(symbol);
                ovf_next    = !first && ovf_reg;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (ctl.restart)
        begin
            found_next = 1'b0;
        end
        if (is_end)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= '0;
            wild_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            found_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            length_reg    <= length_next;
            wild_reg      <= wild_next;
            ovf_reg       <= ovf_next;
            found_reg     <= found_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_end)
        begin
            matched_reg <= answer;
            rsp_ovf_reg <= ovf_reg;
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign matched          = matched_reg;
    assign pattern_overflow = rsp_ovf_reg;

    a_ovf_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && pattern_overflow |-> !matched)
        else $error("overflowed pattern reported a match");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= LEN_W'(PATTERN_MAX))
        else $error("pattern length beyond store");

    a_first_len: assert property (@(posedge clk) disable iff (!rst_n)
        is_pat && first |=> length_reg == LEN_W'(1))
        else $error("new pattern did not restart length");

    a_restart_set: assert property (@(posedge clk) disable iff (!rst_n)
        is_pat |=> raw == NPOS'(1))
        else $error("scan not restarted at position zero");

    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        is_end |=> rsp_valid)
        else $error("end request produced no result");

endmodule

// File: tb/glob_or_substring_path_match_tb.sv
`timescale 1ns / 1ps

module glob_or_substring_path_match_tb;

    import gspm_pkg::*;

    localparam int unsigned PAT_DEPTH = PATTERN_MAX_DEF;
    localparam logic [1:0]  OP_UNUSED = 2'd3;

    typedef struct packed {
        logic matched;
        logic overflow;
    } verdict_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cmd_valid = 1'b0;
    logic       cmd_ready;
    logic [1:0] op = OP_UNUSED;
    logic [7:0] symbol = 8'h00;
    logic       first = 1'b0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    logic       matched;
    logic       pattern_overflow;

    // predicted matcher state
    logic [7:0]  exp_pattern [PAT_DEPTH];
    int unsigned exp_len = 0;
    bit          exp_wild = 1'b0;
    bit          exp_overflow = 1'b0;
    logic [63:0] exp_active = 64'd1;
    bit          exp_found = 1'b0;

    verdict_t    pending_verdicts [$];
    logic [7:0]  pat_q [$];
    logic [7:0]  text_q [$];
    int          errors = 0;
    int          requests_sent = 0;
    bit          idle_on = 1'b1;
    int          stall_left = 0;

    glob_or_substring_path_match dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd_valid        (cmd_valid),
        .cmd_ready        (cmd_ready),
        .op               (op),
        .symbol           (symbol),
        .first            (first),
        .rsp_valid        (rsp_valid),
        .rsp_ready        (rsp_ready),
        .matched          (matched),
        .pattern_overflow (pattern_overflow)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [63:0] star_closure(input logic [63:0] set);
        for (int i = 0; i < exp_len; i++)
        begin
            if (set[i] && exp_pattern[i] == STAR_BYTE)
                set[i + 1] = 1'b1;
        end
        return set;
    endfunction

    function automatic void scan_restart();
        exp_active = star_closure(64'd1);
        exp_found  = 1'b0;
    endfunction

    function automatic void scan_byte(input logic [7:0] c);
        logic [63:0] nxt;
        nxt = '0;
        for (int i = 0; i < exp_len; i++)
        begin
            if (exp_active[i])
            begin
                if (exp_pattern[i] == STAR_BYTE)
                    nxt[i] = 1'b1;
                else if (exp_pattern[i] == QMARK_BYTE || exp_pattern[i] == c)
                    nxt[i + 1] = 1'b1;
            end
        end
        // plain substring search may start at any text position
        if (!exp_wild)
            nxt[0] = 1'b1;
        exp_active = star_closure(nxt);
        if (!exp_wild && exp_active[exp_len])
            exp_found = 1'b1;
    endfunction

    function automatic void predict_request(input logic [1:0] o, input logic [7:0] s,
                                            input logic f);
        verdict_t v;
        bit       at_end;
        if (o == OP_PATTERN)
        begin
            if (f)
            begin
                exp_len      = 0;
                exp_wild     = 1'b0;
                exp_overflow = 1'b0;
            end
            if (exp_len < PAT_DEPTH)
            begin
                exp_pattern[exp_len] = s;
                exp_len++;
                if (s == STAR_BYTE || s == QMARK_BYTE)
                    exp_wild = 1'b1;
            end
            else
                exp_overflow = 1'b1;
            scan_restart();
        end
        else if (o == OP_TEXT)
            scan_byte(s);
        else if (o == OP_END)
        begin
            at_end = exp_active[exp_len];
            if (exp_overflow)
                v.matched = 1'b0;
            else if (exp_wild)
                v.matched = at_end;
            else
                v.matched = exp_found || at_end;
            v.overflow = exp_overflow;
            pending_verdicts = {pending_verdicts, v};
            scan_restart();
        end
    endfunction

    task automatic send_request(input logic [1:0] o, input logic [7:0] s, input logic f);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        op        <= o;
        symbol    <= s;
        first     <= f;
        do
            @(posedge clk);
        while (!cmd_ready);
        predict_request(o, s, f);
        if (o != OP_UNUSED)
            requests_sent++;
    endtask

    task automatic send_string(input logic [1:0] o, input string str, input bit restart);
        for (int i = 0; i < str.len(); i++)
            send_request(o, str[i], restart && i == 0);
    endtask

    function automatic logic [7:0] pick_symbol(input bit wild_ok);
        logic [7:0] b;
        case ($urandom_range(0, 8))
            0, 1:    b = "a";
            2:       b = "b";
            3:       b = "/";
            4:       b = ".";
            5:       b = STAR_BYTE;
            6:       b = QMARK_BYTE;
            default: b = 8'($urandom_range(0, 255));
        endcase
        if (!wild_ok && (b == STAR_BYTE || b == QMARK_BYTE))
            b = "c";
        return b;
    endfunction

    // mostly texts that follow the pattern, some damaged, some unrelated
    function automatic void build_text(input bit wild_ok);
        int mode;
        int pos;
        mode = $urandom_range(0, 5);
        text_q.delete();
        if (mode <= 3)
        begin
            if (!wild_ok)
                repeat ($urandom_range(0, 3)) text_q = {text_q, pick_symbol(1'b0)};
            foreach (pat_q[i])
            begin
                if (pat_q[i] == STAR_BYTE)
                    repeat ($urandom_range(0, 3)) text_q = {text_q, pick_symbol(1'b1)};
                else if (pat_q[i] == QMARK_BYTE)
                    text_q = {text_q, 8'($urandom_range(0, 255))};
                else
                    text_q = {text_q, pat_q[i]};
            end
            if (!wild_ok)
                repeat ($urandom_range(0, 3)) text_q = {text_q, pick_symbol(1'b0)};
            if (mode == 3 && text_q.size() > 0)
            begin
                pos = $urandom_range(0, text_q.size() - 1);
                if ($urandom_range(0, 1))
                    text_q[pos] = text_q[pos] ^ 8'h01;
                else
                    text_q.delete(pos);
            end
        end
        else
            repeat ($urandom_range(0, 10)) text_q = {text_q, pick_symbol(1'b1)};
    endfunction

    // result channel stalls in bursts while idling is enabled
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_ready <= 1'b0;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            rsp_ready <= 1'b0;
            stall_left = $urandom_range(0, 17);
        end
        else
            rsp_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: response with none expected: matched=%b overflow=%b",
                         $time, matched, pattern_overflow);
                errors++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (matched !== want.matched)
                begin
                    $display("%0t: matched expected %b actual %b",
                             $time, want.matched, matched);
                    errors++;
                end
                if (pattern_overflow !== want.overflow)
                begin
                    $display("%0t: pattern_overflow expected %b actual %b",
                             $time, want.overflow, pattern_overflow);
                    errors++;
                end
            end
        end
    end

    // reset leaves an empty pattern that matches every text
    task automatic test_empty_pattern();
        send_string(OP_TEXT, "ab", 1'b0);
        send_request(OP_END, 8'h00, 1'b0);
        send_request(OP_END, 8'hFF, 1'b1);
    endtask

    task automatic test_substring();
        send_string(OP_PATTERN, "ab", 1'b1);
        send_string(OP_TEXT, "xaby", 1'b0);
        send_request(OP_END, 8'h00, 1'b0);
        send_string(OP_TEXT, "ba", 1'b0);
        send_request(OP_END, 8'h00, 1'b0);
        // byte extremes in both pattern and text
        send_request(OP_PATTERN, 8'hFF, 1'b1);
        send_request(OP_PATTERN, 8'h00, 1'b0);
        send_request(OP_TEXT, 8'h00, 1'b1);
        send_request(OP_TEXT, 8'hFF, 1'b0);
        send_request(OP_TEXT, 8'h00, 1'b0);
        send_request(OP_END, 8'h00, 1'b0);
    endtask

    task automatic test_glob();
        send_request(OP_PATTERN, STAR_BYTE, 1'b1);
        send_request(OP_END, 8'h00, 1'b0);
        send_request(OP_PATTERN, "a", 1'b1);
        send_request(OP_PATTERN, QMARK_BYTE, 1'b0);
        send_string(OP_TEXT, "ab", 1'b0);
        send_request(OP_END, 8'h00, 1'b0);
        send_request(OP_TEXT, "a", 1'b0);
        send_request(OP_END, 8'h00, 1'b0);
    endtask

    // unused op in mid text and a pattern that grows after text bytes
    task automatic test_pattern_after_text();
        send_string(OP_PATTERN, "ab", 1'b1);
        send_request(OP_TEXT, "a", 1'b0);
        send_request(OP_UNUSED, "b", 1'b1);
        send_request(OP_PATTERN, "c", 1'b0);
        send_string(OP_TEXT, "abc", 1'b0);
        send_request(OP_END, 8'h00, 1'b0);
    endtask

    task automatic test_overflow();
        for (int i = 0; i <= PAT_DEPTH; i++)
            send_request(OP_PATTERN, "a", i == 0);
        send_request(OP_TEXT, "a", 1'b0);
        send_request(OP_END, 8'h00, 1'b0);
        send_request(OP_PATTERN, "a", 1'b1);
        send_request(OP_TEXT, "a", 1'b0);
        send_request(OP_END, 8'h00, 1'b0);
    endtask

    task automatic test_random_sequences(input int target, input bit allow_idle);
        int  plen;
        bit  wild_ok;
        idle_on = allow_idle;
        while (requests_sent < target)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
                continue;
            end
            wild_ok = $urandom_range(0, 2) != 0;
            plen = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 66)
                                                : $urandom_range(1, 8);
            pat_q.delete();
            repeat (plen) pat_q = {pat_q, pick_symbol(wild_ok)};
            foreach (pat_q[i])
                send_request(OP_PATTERN, pat_q[i], i == 0);
            repeat ($urandom_range(1, 4))
            begin
                build_text(wild_ok);
                foreach (text_q[i])
                    send_request(OP_TEXT, text_q[i], 1'($urandom_range(0, 1)));
                send_request(OP_END, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_pattern();
        test_substring();
        test_glob();
        test_pattern_after_text();
        test_overflow();
        test_random_sequences(1050, 1'b1);
        test_random_sequences(1250, 1'b0);
        cmd_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0 && pending_verdicts.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
